### rtl/autokey_cipher_stream_defines.svh
// Assertion macros of the autokey cipher RTL.
`ifndef AUTOKEY_CIPHER_STREAM_DEFINES_SVH
`define AUTOKEY_CIPHER_STREAM_DEFINES_SVH

// Property checked on every rising clock edge outside reset.
`define ACS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked on every rising clock edge outside reset.
`define ACS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

### rtl/acs_pkg.sv
// Types, constants and helper functions of the autokey cipher stream.
package acs_pkg;

  localparam int CHAR_W     = 8;
  localparam int LETTER_W   = 5;
  localparam int LEN_W      = 5;
  localparam int HALF_W     = 60;
  localparam int HALF_SLOTS = 12;
  localparam int PRIMER_MAX = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int SUM_W      = 6;
  localparam int ALPHA      = 26;

  localparam logic [CHAR_W-1:0] ASCII_A  = 8'd65;
  localparam logic [CHAR_W-1:0] ASCII_Z  = 8'd90;
  localparam logic [CHAR_W-1:0] ASCII_LA = 8'd97;
  localparam logic [CHAR_W-1:0] ASCII_LZ = 8'd122;

  localparam logic [CFG_IDX_W-1:0] REG_MODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PLEN     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRIMER_0 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PRIMER_1 = 2'd3;

  localparam logic MODE_ENC = 1'b0;

  typedef logic [LETTER_W-1:0] letter_t;
  typedef logic [CHAR_W-1:0]   char_t;

  // Primer letter idx from the two halves, folded into 0..25.
  function automatic letter_t primer_letter(input logic [HALF_W-1:0] h0,
                                            input logic [HALF_W-1:0] h1,
                                            input int idx);
    letter_t v;
    if (idx < HALF_SLOTS) begin
      v = h0[LETTER_W*idx +: LETTER_W];
    end else begin
      v = h1[LETTER_W*(idx-HALF_SLOTS) +: LETTER_W];
    end
    return (v >= LETTER_W'(ALPHA)) ? letter_t'(v - LETTER_W'(ALPHA)) : v;
  endfunction

  // Fold a sum in 0..51 into 0..25.
  function automatic letter_t wrap26(input logic [SUM_W-1:0] s);
    logic [SUM_W-1:0] r;
    r = (s >= SUM_W'(ALPHA)) ? SUM_W'(s - SUM_W'(ALPHA)) : s;
    return r[LETTER_W-1:0];
  endfunction

endpackage

### rtl/acs_ifs.sv
// Valid/ready channel interfaces of the autokey cipher stream.
interface acs_in_if;
  logic                     valid;
  logic                     ready;
  logic [acs_pkg::CHAR_W-1:0] in_char;
  logic                     message_start;

  modport source (output valid, output in_char, output message_start, input ready);
  modport sink   (input valid, input in_char, input message_start, output ready);
endinterface

interface acs_out_if;
  logic                       valid;
  logic                       ready;
  logic [acs_pkg::CHAR_W-1:0] out_char;

  modport source (output valid, output out_char, input ready);
  modport sink   (input valid, input out_char, output ready);
endinterface

interface acs_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [acs_pkg::CFG_IDX_W-1:0] index;
  logic [acs_pkg::HALF_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/autokey_cipher_stream.sv
// Autokey Vigenere cipher, one byte per request, key ring in a small RAM.
//
// Each accepted character yields one result character. A new request is taken
// every cycle unless the output stalls; a result goes through stage 1 and the
// output register, and the pipeline holds one more request behind a stalled
// output register. The key ring sits in a KEY_MAX x 5 RAM: a slot is read when
// the request is accepted and written back with the plain letter as it leaves
// stage 1, so two requests on the same slot in a row are served by forwarding.
// A request with message_start reloads the ring at once: the primer is latched
// into a snapshot and per-slot valid bits clear, so an unwritten slot reads its
// primer letter. Letters of either case give uppercase letters; other bytes
// pass through and leave the key alone. Configuration writes are taken every
// cycle and must only occur while no request is in flight; the primer length
// is used live, the primer letters only at the next message_start.
module autokey_cipher_stream #(
  parameter int KEY_MAX = 24
) (
  input  logic          clk,
  input  logic          rst_n,
  acs_in_if.sink        in_req,
  acs_out_if.source     out_rsp,
  acs_cfg_if.sink       cfg_wr
);
  import acs_pkg::*;

  `include "autokey_cipher_stream_defines.svh"

  localparam int IDX_W = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
  localparam int NSNAP = (KEY_MAX < PRIMER_MAX) ? KEY_MAX : PRIMER_MAX;

  // configuration
  logic               mode_r;
  logic [LEN_W-1:0]   plen_r;
  logic [HALF_W-1:0]  half0_r;
  logic [HALF_W-1:0]  half1_r;

  // control
  logic               s1_valid_r;
  logic               out_valid_r;
  logic [IDX_W-1:0]   ring_pos_r;
  logic [IDX_W-1:0]   ring_pos_nxt;
  logic [KEY_MAX-1:0] slot_valid_r;
  logic [KEY_MAX-1:0] slot_valid_nxt;

  // stage 1 payload
  logic               s1_letter_r;
  char_t              s1_char_r;
  letter_t            s1_val_r;
  logic [IDX_W-1:0]   s1_pos_r;
  logic               s1_fwd_r;
  letter_t            s1_fwd_data_r;
  letter_t            rd_data_r;
  char_t              out_char_r;

  letter_t            snap_r [KEY_MAX];
  letter_t            ring_mem [KEY_MAX];

  logic               in_fire;
  logic               s1_fire;
  logic               in_start;
  logic               in_upper;
  logic               in_lower;
  logic               in_letter;
  letter_t            in_val;
  logic [LEN_W-1:0]   len_eff;
  logic [IDX_W-1:0]   pos_base;
  logic [IDX_W-1:0]   pos0;
  logic [LEN_W-1:0]   pos_inc;
  logic [IDX_W-1:0]   pos_adv;
  letter_t            key;
  letter_t            res;
  letter_t            plain;
  logic [SUM_W-1:0]   enc_sum;
  logic [SUM_W-1:0]   dec_sum;
  char_t              out_char_nxt;

  // handshakes
  assign s1_fire       = s1_valid_r & (~out_valid_r | out_rsp.ready);
  assign in_req.ready  = ~s1_valid_r | s1_fire;
  assign in_fire       = in_req.valid & in_req.ready;
  assign in_start      = in_req.message_start;
  assign cfg_wr.ready  = 1'b1;
  assign out_rsp.valid    = out_valid_r;
  assign out_rsp.out_char = out_char_r;

  // stage 0: classify and pick the ring slot
  always_comb begin
    in_upper  = in_req.in_char inside {[ASCII_A:ASCII_Z]};
    in_lower  = in_req.in_char inside {[ASCII_LA:ASCII_LZ]};
    in_letter = in_upper | in_lower;
    in_val    = in_upper ? LETTER_W'(in_req.in_char - ASCII_A)
                         : LETTER_W'(in_req.in_char - ASCII_LA);
    if (plen_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (plen_r > LEN_W'(KEY_MAX)) begin
      len_eff = LEN_W'(KEY_MAX);
    end else begin
      len_eff = plen_r;
    end
    pos_base = in_start ? '0 : ring_pos_r;
    pos0     = (LEN_W'(pos_base) >= len_eff) ? '0 : pos_base;
    pos_inc  = LEN_W'(pos0) + LEN_W'(1);
    pos_adv  = (pos_inc >= len_eff) ? '0 : IDX_W'(pos_inc);
    ring_pos_nxt = ring_pos_r;
    if (in_fire) begin
      ring_pos_nxt = in_letter ? pos_adv : pos_base;
    end
  end

  // stage 1: key lookup and mod-26 arithmetic
  always_comb begin
    if (s1_fwd_r) begin
      key = s1_fwd_data_r;
    end else if (slot_valid_r[s1_pos_r]) begin
      key = rd_data_r;
    end else begin
      key = snap_r[s1_pos_r];
    end
    enc_sum = SUM_W'(s1_val_r) + SUM_W'(key);
    dec_sum = SUM_W'(s1_val_r) + SUM_W'(ALPHA) - SUM_W'(key);
    res     = (mode_r == MODE_ENC) ? wrap26(enc_sum) : wrap26(dec_sum);
    plain   = (mode_r == MODE_ENC) ? s1_val_r : res;
    out_char_nxt = s1_letter_r ? char_t'(ASCII_A + CHAR_W'(res)) : s1_char_r;
  end

  always_comb begin
    slot_valid_nxt = slot_valid_r;
    if (in_fire && in_start) begin
      slot_valid_nxt = '0;
    end else if (s1_fire && s1_letter_r) begin
      slot_valid_nxt[s1_pos_r] = 1'b1;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 1'b0;
      plen_r  <= LEN_W'(1);
      half0_r <= '0;
      half1_r <= '0;
    end else if (cfg_wr.valid && cfg_wr.ready) begin
      case (cfg_wr.index)
        REG_MODE:     mode_r  <= cfg_wr.data[0];
        REG_PLEN:     plen_r  <= cfg_wr.data[LEN_W-1:0];
        REG_PRIMER_0: half0_r <= cfg_wr.data;
        REG_PRIMER_1: half1_r <= cfg_wr.data;
        default: ;
      endcase
    end
  end

  // control state and primer snapshot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      ring_pos_r   <= '0;
      slot_valid_r <= '0;
      for (int i = 0; i < KEY_MAX; i++) begin
        snap_r[i] <= '0;
      end
    end else begin
      ring_pos_r   <= ring_pos_nxt;
      slot_valid_r <= slot_valid_nxt;
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
      if (in_fire && in_start) begin
        for (int i = 0; i < KEY_MAX; i++) begin
          snap_r[i] <= (i < NSNAP) ? primer_letter(half0_r, half1_r, i) : '0;
        end
      end
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_letter_r   <= in_letter;
      s1_char_r     <= in_req.in_char;
      s1_val_r      <= in_val;
      s1_pos_r      <= pos0;
      s1_fwd_r      <= s1_fire & s1_letter_r & ~in_start & (s1_pos_r == pos0);
      s1_fwd_data_r <= plain;
    end
    if (s1_fire) begin
      out_char_r <= out_char_nxt;
    end
  end

  // key ring RAM
  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_data_r <= ring_mem[pos0];
    end
    if (s1_fire && s1_letter_r) begin
      ring_mem[s1_pos_r] <= plain;
    end
  end

  `ACS_ASSERT(a_pos_in_ring, LEN_W'(ring_pos_r) < LEN_W'(KEY_MAX), "ring position out of range")
  `ACS_ASSERT_IMPL(a_stall_blocks, s1_valid_r && out_valid_r && !out_rsp.ready, !in_req.ready, "request taken while pipeline full")
  `ACS_ASSERT_IMPL(a_start_clears, in_fire && in_start, ##1 ($countones(slot_valid_r) == 0), "ring not reloaded on message start")
  `ACS_ASSERT_IMPL(a_result_upper, s1_fire && s1_letter_r, ##1 (out_valid_r && out_char_r >= ASCII_A && out_char_r <= ASCII_Z), "letter result not uppercase")

endmodule

### sim/autokey_cipher_stream_tb.sv
// Self-checking testbench of the autokey cipher stream: directed and random character traffic.
module autokey_cipher_stream_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import acs_pkg::*;

  localparam logic MODE_DEC = ~MODE_ENC;
  localparam int   RANDOM_REQS = 750;
  localparam int   QUIET_FROM = 650;

  typedef struct packed {
    char_t ch;
    logic  start;
  } cipher_req_t;

  logic clk;
  logic rst_n;

  acs_in_if  in_req();
  acs_out_if out_rsp();
  acs_cfg_if cfg_wr();

  autokey_cipher_stream u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp),
    .cfg_wr  (cfg_wr)
  );

  // predictor state
  logic              cfg_mode;
  logic [LEN_W-1:0]  cfg_plen;
  logic [HALF_W-1:0] primer_lo;
  logic [HALF_W-1:0] primer_hi;
  letter_t           key_letters [PRIMER_MAX];
  int                key_slot;

  cipher_req_t pending_reqs [$];
  char_t       expected_chars [$];

  int n_pushed = 0;
  int n_accepted = 0;
  int n_checked = 0;
  int n_errors = 0;
  int n_letters = 0;
  int n_msgs = 0;
  int n_cfg = 0;
  int n_random = 0;

  bit in_taken = 1'b0;
  bit cfg_taken = 1'b0;
  bit quiet = 1'b0;
  int in_gap = 0;
  int out_gap = 0;
  int in_idle_pct = 20;
  int out_idle_pct = 20;

  cipher_req_t drv_req;
  char_t       want_char;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  task automatic report_mismatch(input string what, input char_t got, input char_t want);
    $display("%0t ns: mismatch, %s: got 8'h%02h, expected 8'h%02h", $realtime, what, got, want);
    n_errors++;
  endtask

  function automatic void reload_key_ring();
    logic [LETTER_W-1:0] v;
    for (int i = 0; i < PRIMER_MAX; i++) begin
      v = (i < HALF_SLOTS) ? primer_lo[LETTER_W*i +: LETTER_W]
                           : primer_hi[LETTER_W*(i-HALF_SLOTS) +: LETTER_W];
      key_letters[i] = letter_t'(int'(v) % ALPHA);
    end
    key_slot = 0;
  endfunction

  function automatic char_t cipher_predict(input char_t ch, input logic start);
    int plain_l;
    int res_l;
    int key_l;
    int len;
    int slot;
    if (start) reload_key_ring();
    if (ch >= ASCII_A && ch <= ASCII_Z) begin
      plain_l = ch - ASCII_A;
    end else if (ch >= ASCII_LA && ch <= ASCII_LZ) begin
      plain_l = ch - ASCII_LA;
    end else begin
      return ch;
    end
    len = (cfg_plen == 0) ? 1 : ((cfg_plen > PRIMER_MAX) ? PRIMER_MAX : int'(cfg_plen));
    slot = (key_slot >= len) ? 0 : key_slot;
    key_l = key_letters[slot];
    if (cfg_mode == MODE_ENC) begin
      res_l = (plain_l + key_l) % ALPHA;
    end else begin
      res_l = (plain_l + ALPHA - key_l) % ALPHA;
      plain_l = res_l;
    end
    key_letters[slot] = letter_t'(plain_l);
    slot++;
    key_slot = (slot >= len) ? 0 : slot;
    return char_t'(res_l + ASCII_A);
  endfunction

  // monitor: requests, results and register writes at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_wr.valid && cfg_wr.ready) begin
        case (cfg_wr.index)
          REG_MODE:     cfg_mode = cfg_wr.data[0];
          REG_PLEN:     cfg_plen = cfg_wr.data[LEN_W-1:0];
          REG_PRIMER_0: primer_lo = cfg_wr.data;
          REG_PRIMER_1: primer_hi = cfg_wr.data;
          default: ;
        endcase
        cfg_taken = 1'b1;
        n_cfg++;
      end
      if (in_req.valid && in_req.ready) begin
        expected_chars.push_back(cipher_predict(in_req.in_char, in_req.message_start));
        in_taken = 1'b1;
        n_accepted++;
      end
      if (out_rsp.valid && out_rsp.ready) begin
        if (expected_chars.size() == 0) begin
          report_mismatch("result with no request pending", out_rsp.out_char, 8'h00);
        end else begin
          want_char = expected_chars.pop_front();
          if (out_rsp.out_char !== want_char)
            report_mismatch("out_char", out_rsp.out_char, want_char);
          n_checked++;
        end
      end
    end
  end

  // request driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_req.valid <= 1'b0;
    end else if (!in_req.valid || in_taken) begin
      in_taken = 1'b0;
      if (in_gap > 0 && !quiet) begin
        in_gap--;
        in_req.valid <= 1'b0;
      end else if (pending_reqs.size() == 0) begin
        in_req.valid <= 1'b0;
      end else if (!quiet && $urandom_range(1, 100) <= in_idle_pct) begin
        in_gap = $urandom_range(0, 7);
        in_req.valid <= 1'b0;
      end else begin
        drv_req = pending_reqs.pop_front();
        in_req.valid <= 1'b1;
        in_req.in_char <= drv_req.ch;
        in_req.message_start <= drv_req.start;
      end
    end
  end

  // result stalls
  always @(negedge clk) begin
    if (!rst_n) begin
      out_rsp.ready <= 1'b0;
    end else if (out_gap > 0 && !quiet) begin
      out_gap--;
      out_rsp.ready <= 1'b0;
    end else if (!quiet && $urandom_range(1, 100) <= out_idle_pct) begin
      out_gap = $urandom_range(0, 7);
      out_rsp.ready <= 1'b0;
    end else begin
      out_rsp.ready <= 1'b1;
    end
  end

  task automatic push_req(input char_t ch, input logic start);
    cipher_req_t r;
    r.ch = ch;
    r.start = start;
    pending_reqs.push_back(r);
    n_pushed++;
    if (start) n_msgs++;
    if ((ch >= ASCII_A && ch <= ASCII_Z) || (ch >= ASCII_LA && ch <= ASCII_LZ)) n_letters++;
  endtask

  task automatic push_text(input string s, input logic start);
    for (int i = 0; i < s.len(); i++) push_req(char_t'(s[i]), start && i == 0);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (!(n_accepted == n_pushed && expected_chars.size() == 0));
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [HALF_W-1:0] value);
    @(negedge clk);
    cfg_taken = 1'b0;
    cfg_wr.valid <= 1'b1;
    cfg_wr.index <= idx;
    cfg_wr.data <= value;
    do @(negedge clk);
    while (!cfg_taken);
    cfg_wr.valid <= 1'b0;
  endtask

  function automatic logic [HALF_W-1:0] random_primer();
    logic [HALF_W-1:0] h;
    if ($urandom_range(0, 7) == 0) return '1;
    for (int i = 0; i < HALF_SLOTS; i++)
      h[LETTER_W*i +: LETTER_W] = ($urandom_range(0, 9) == 0)
                                  ? LETTER_W'($urandom_range(26, 31))
                                  : LETTER_W'($urandom_range(0, 25));
    return h;
  endfunction

  function automatic char_t rand_text_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return char_t'(ASCII_A + $urandom_range(0, 25));
    if (r < 70) return char_t'(ASCII_LA + $urandom_range(0, 25));
    if (r < 80) return char_t'($urandom_range(32, 64));
    if (r < 88) begin
      case ($urandom_range(0, 7))
        0: return char_t'(ASCII_A - 1);
        1: return char_t'(ASCII_Z + 1);
        2: return char_t'(ASCII_LA - 1);
        3: return char_t'(ASCII_LZ + 1);
        4: return ASCII_A;
        5: return ASCII_Z;
        6: return ASCII_LA;
        default: return ASCII_LZ;
      endcase
    end
    return char_t'($urandom_range(0, 255));
  endfunction

  initial begin
    int plen_pick [5];
    int phase;
    int msgs;
    int msg_len;
    bit continuing;

    plen_pick = '{24, 1, 0, 31, 25};
    rst_n = 1'b0;
    in_req.valid = 1'b0;
    in_req.in_char = '0;
    in_req.message_start = 1'b0;
    out_rsp.ready = 1'b0;
    cfg_wr.valid = 1'b0;
    cfg_wr.index = REG_MODE;
    cfg_wr.data = '0;
    cfg_mode = MODE_ENC;
    cfg_plen = LEN_W'(1);
    primer_lo = '0;
    primer_hi = '0;
    reload_key_ring();
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // reset key, letter and byte boundaries
    push_text("Az@[`{", 1'b0);
    push_req(8'h00, 1'b0);
    push_req(8'hFF, 1'b0);
    push_req(8'h80, 1'b0);
    push_req(8'h7F, 1'b0);
    push_text("M", 1'b1);
    wait_idle();

    // decrypt, primer letters above Z fold back, upper half all ones
    cfg_write(REG_MODE, HALF_W'(MODE_DEC));
    cfg_write(REG_PLEN, HALF_W'(5));
    cfg_write(REG_PRIMER_0, {35'd0, 5'd13, 5'd0, 5'd25, 5'd26, 5'd31});
    cfg_write(REG_PRIMER_1, '1);
    push_text("QbZa~", 1'b1);
    wait_idle();

    // shorten the primer mid-message: slot 4 is now past the end
    cfg_write(REG_PLEN, HALF_W'(2));
    push_text("Hi", 1'b0);
    wait_idle();
    cfg_write(REG_PLEN, HALF_W'(0));
    push_text("x", 1'b1);
    wait_idle();
    cfg_write(REG_PLEN, HALF_W'(31));
    cfg_write(REG_MODE, HALF_W'(MODE_ENC));
    push_text("T", 1'b1);

    phase = 0;
    while (n_random < RANDOM_REQS) begin
      wait_idle();
      quiet = (n_random >= QUIET_FROM);
      case ($urandom_range(0, 3))
        0: in_idle_pct = 0;
        1: in_idle_pct = 10;
        2: in_idle_pct = 30;
        default: in_idle_pct = 60;
      endcase
      case ($urandom_range(0, 3))
        0: out_idle_pct = 0;
        1: out_idle_pct = 10;
        2: out_idle_pct = 30;
        default: out_idle_pct = 60;
      endcase
      if (phase < 5)
        cfg_write(REG_PLEN, HALF_W'(plen_pick[phase]));
      else if ($urandom_range(0, 1))
        cfg_write(REG_PLEN, HALF_W'($urandom_range(0, 3) == 0 ? $urandom_range(0, 31)
                                                               : $urandom_range(1, 24)));
      if (phase == 0 || $urandom_range(0, 1))
        cfg_write(REG_MODE, HALF_W'($urandom_range(0, 1)));
      if (phase == 0 || $urandom_range(0, 9) < 7) cfg_write(REG_PRIMER_0, random_primer());
      if (phase == 0 || $urandom_range(0, 9) < 6) cfg_write(REG_PRIMER_1, random_primer());
      continuing = (phase > 0 && $urandom_range(0, 3) == 0);
      msgs = $urandom_range(1, 4);
      for (int m = 0; m < msgs; m++) begin
        msg_len = $urandom_range(1, 40);
        for (int k = 0; k < msg_len; k++) begin
          push_req(rand_text_char(), k == 0 && !(m == 0 && continuing));
          n_random++;
        end
      end
      phase++;
    end

    wait_idle();
    repeat (10) @(negedge clk);
    foreach (expected_chars[i])
      report_mismatch("no result for request", 8'h00, expected_chars[i]);
    $display("Ran %0d requests (%0d letters) in %0d messages over %0d register writes.",
             n_pushed, n_letters, n_msgs, n_cfg);
    $display("Checked %0d results, %0d mismatches.", n_checked, n_errors);
    if (n_errors == 0 && expected_chars.size() == 0) begin
      $display("autokey_cipher_stream_tb passed");
    end else begin
      $display("autokey_cipher_stream_tb failed");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Timeout with %0d results still expected.", expected_chars.size());
    $display("autokey_cipher_stream_tb failed");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/acs_pkg.sv
rtl/acs_ifs.sv
rtl/autokey_cipher_stream.sv
sim/autokey_cipher_stream_tb.sv
